[hdl/cfa_pkg.sv]
// Shared constants, codes and types for the contiguous fit allocator.
package cfa_pkg;

  localparam int NUM_BLOCKS = 64;
  localparam int SIZE_WIDTH = 16;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

  // fixed field widths of the item formats
  localparam int OP_W     = 2;
  localparam int BLKIDX_W = 6;
  localparam int REQ_W    = 16;
  localparam int STAT_W   = 2;
  localparam int GRANT_W  = 6;
  localparam int REM_W    = 16;
  localparam int MODE_W   = 2;
  localparam int BIU_W    = 7;
  localparam int LIM_W    = (CNT_W > BIU_W) ? CNT_W : BIU_W;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [BIU_W-1:0] BIU_RESET = BIU_W'(64);

  // operations
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_RESTORE = 2'd1;
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd2;

  // result status
  localparam logic [STAT_W-1:0] STAT_ALLOCATED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_FIT    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_REFUSED   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_DONE      = 2'd3;

  // fit modes
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS   = 2'd1;

  typedef struct packed {
    logic                clear;
    logic                sample;
    logic [MODE_W-1:0]   mode;
  } pick_ctl_t;

endpackage

[hdl/contiguous_fit_allocator_top.sv]
// Top level of the contiguous fit allocator: control, size tables and stream ports.
// Load, an unused op or a refused allocate goes straight to the result state; restore first
// sweeps all NUM_BLOCKS entries, allocate first scans min(blocks_in_use,NUM_BLOCKS) blocks.
// One item is worked at a time; the free-size memory is scanned one block per cycle.
// Synchronous active-low reset clears control and per-entry valid bits; both tables then
// read as zero without a clearing pass. fit_mode resets to first fit, blocks_in_use to 64.
module contiguous_fit_allocator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: block_index[5:0], request_size[21:6], zero pad[23:22]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [cfa_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [cfa_pkg::OP_W-1:0]        in_tuser,   // operation
  // out_tdata: granted_block[5:0], remaining_size[21:6], zero pad[23:22]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cfa_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [cfa_pkg::STAT_W-1:0]      out_tuser,  // status
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cfa_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cfa_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                  halted_r, halted_nxt;
  logic [MODE_W-1:0]     fit_mode_r;
  logic [BIU_W-1:0]      blocks_r;
  logic [NUM_BLOCKS-1:0] init_vld_r, free_vld_r;

  logic [SIZE_WIDTH-1:0] req_r, req_nxt;
  logic [STAT_W-1:0]     res_stat_r, res_stat_nxt;
  logic [GRANT_W-1:0]    res_blk_r, res_blk_nxt;
  logic [REM_W-1:0]      res_rem_r, res_rem_nxt;

  logic                  out_vld_r;
  logic [STAT_W-1:0]     out_stat_r;
  logic [GRANT_W-1:0]    out_blk_r;
  logic [REM_W-1:0]      out_rem_r;

  logic [SIZE_WIDTH-1:0] init_mem [NUM_BLOCKS];
  logic [SIZE_WIDTH-1:0] free_mem [NUM_BLOCKS];
  logic [SIZE_WIDTH-1:0] init_q_r, free_q_r;
  logic                  init_qv_r, free_qv_r;

  logic                  in_xfer, out_slot_free;
  logic [OP_W-1:0]       in_op;
  logic [BLKIDX_W-1:0]   in_blk;
  logic [REQ_W-1:0]      in_req;
  logic                  init_we;
  logic [IDX_W-1:0]      init_wa;
  logic                  free_we;
  logic [IDX_W-1:0]      free_wa;
  logic [SIZE_WIDTH-1:0] free_wd;
  logic [IDX_W-1:0]      rd_addr;
  logic [LIM_W-1:0]      biu_ext;
  logic [CNT_W-1:0]      limit;
  logic [SIZE_WIDTH-1:0] scan_size;

  pick_ctl_t             pick_ctl;
  logic                  pick_found;
  logic [IDX_W-1:0]      pick_idx;
  logic [SIZE_WIDTH-1:0] pick_size;

  assign in_op   = in_tuser;
  assign in_blk  = in_tdata[BLKIDX_W-1:0];
  assign in_req  = in_tdata[BLKIDX_W+REQ_W-1:BLKIDX_W];

  assign in_tready     = (state_r == S_IDLE);
  assign in_xfer       = in_tvalid && in_tready;
  assign out_slot_free = !out_vld_r || out_tready;
  assign cfg_ready     = 1'b1;

  assign rd_addr = cnt_r[IDX_W-1:0];
  assign biu_ext = LIM_W'(blocks_r);
  assign limit   = (biu_ext > LIM_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(blocks_r);
  assign scan_size = free_qv_r ? free_q_r : '0;

  // load writes the initial table straight from the input transfer
  assign init_we = in_xfer && (in_op == OP_LOAD) && (32'(in_blk) < NUM_BLOCKS);
  assign init_wa = IDX_W'(in_blk);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    halted_nxt   = halted_r;
    req_nxt      = req_r;
    res_stat_nxt = res_stat_r;
    res_blk_nxt  = res_blk_r;
    res_rem_nxt  = res_rem_r;
    free_we      = 1'b0;
    free_wa      = rd_idx_r;
    free_wd      = init_qv_r ? init_q_r : '0;
    pick_ctl.clear  = 1'b0;
    pick_ctl.sample = 1'b0;
    pick_ctl.mode   = fit_mode_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          req_nxt      = SIZE_WIDTH'(in_req);
          res_stat_nxt = STAT_DONE;
          res_blk_nxt  = '0;
          res_rem_nxt  = '0;
          cnt_nxt      = '0;
          unique case (in_op)
            OP_RESTORE: state_nxt = S_SWEEP;
            OP_ALLOC: begin
              if (halted_r) begin
                res_stat_nxt = STAT_REFUSED;
                state_nxt    = S_FIN;
              end else begin
                pick_ctl.clear = 1'b1;
                state_nxt      = S_SCAN;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_SWEEP: begin
        // copy initial sizes over the working sizes, one entry per cycle
        if (cnt_r < CNT_W'(NUM_BLOCKS)) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = rd_addr;
          cnt_nxt    = cnt_r + 1'b1;
        end
        if (rd_vld_r) begin
          free_we = 1'b1;
        end
        if ((cnt_r == CNT_W'(NUM_BLOCKS)) && !rd_vld_r) begin
          halted_nxt = 1'b0;
          state_nxt  = S_FIN;
        end
      end
      S_SCAN: begin
        if (cnt_r < limit) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = rd_addr;
          cnt_nxt    = cnt_r + 1'b1;
        end
        pick_ctl.sample = rd_vld_r;
        if ((cnt_r == limit) && !rd_vld_r) begin
          if (pick_found) begin
            free_we      = 1'b1;
            free_wa      = pick_idx;
            free_wd      = pick_size - req_r;
            res_stat_nxt = STAT_ALLOCATED;
            res_blk_nxt  = GRANT_W'(pick_idx);
            res_rem_nxt  = REM_W'(pick_size - req_r);
          end else begin
            halted_nxt   = 1'b1;
            res_stat_nxt = STAT_NO_FIT;
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  cfa_pick u_pick (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (pick_ctl),
    .req       (req_r),
    .size      (scan_size),
    .idx       (rd_idx_r),
    .found     (pick_found),
    .pick_idx  (pick_idx),
    .pick_size (pick_size)
  );

  always_ff @(posedge clk) begin
    if (init_we) begin
      init_mem[init_wa] <= SIZE_WIDTH'(in_req);
    end
    init_q_r  <= init_mem[rd_addr];
    init_qv_r <= init_vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (free_we) begin
      free_mem[free_wa] <= free_wd;
    end
    free_q_r  <= free_mem[rd_addr];
    free_qv_r <= free_vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      rd_vld_r   <= 1'b0;
      halted_r   <= 1'b0;
      fit_mode_r <= MODE_FIRST;
      blocks_r   <= BIU_RESET;
      init_vld_r <= '0;
      free_vld_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= rd_vld_nxt;
      halted_r <= halted_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FIT_MODE: fit_mode_r <= cfg_data[MODE_W-1:0];
          REG_BLOCKS:   blocks_r   <= cfg_data[BIU_W-1:0];
          default:      ;
        endcase
      end
      if (init_we) begin
        init_vld_r[init_wa] <= 1'b1;
      end
      if (free_we) begin
        free_vld_r[free_wa] <= 1'b1;
      end
      if ((state_r == S_FIN) && out_slot_free) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    req_r      <= req_nxt;
    res_stat_r <= res_stat_nxt;
    res_blk_r  <= res_blk_nxt;
    res_rem_r  <= res_rem_nxt;
    if ((state_r == S_FIN) && out_slot_free) begin
      out_stat_r <= res_stat_r;
      out_blk_r  <= res_blk_r;
      out_rem_r  <= res_rem_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {(OUT_DATA_W-GRANT_W-REM_W)'(0), out_rem_r, out_blk_r};

endmodule

[hdl/cfa_pick.sv]
// Candidate selection for the block scan: keeps the first fitting block, or the smallest or largest by fit mode.
module cfa_pick (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfa_pkg::pick_ctl_t             ctl,
  input  logic [cfa_pkg::SIZE_WIDTH-1:0] req,
  input  logic [cfa_pkg::SIZE_WIDTH-1:0] size,
  input  logic [cfa_pkg::IDX_W-1:0]      idx,
  output logic                           found,
  output logic [cfa_pkg::IDX_W-1:0]      pick_idx,
  output logic [cfa_pkg::SIZE_WIDTH-1:0] pick_size
);
  import cfa_pkg::*;

  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      idx_r;
  logic [SIZE_WIDTH-1:0] size_r;
  logic                  take;

  always_comb begin
    take = 1'b0;
    if (ctl.sample && (req <= size)) begin
      if (!found_r) begin
        take = 1'b1;
      end else begin
        case (ctl.mode)
          MODE_BEST:  take = (size < size_r);
          MODE_WORST: take = (size > size_r);
          default:    take = 1'b0;
        endcase
      end
    end
    found_nxt = ctl.clear ? 1'b0 : (found_r | take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      idx_r  <= idx;
      size_r <= size;
    end
  end

  assign found     = found_r;
  assign pick_idx  = idx_r;
  assign pick_size = size_r;

endmodule

[hdl/cfa_checker.sv]
// Port-level checks for the contiguous fit allocator, bound to the top level.
module cfa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cfa_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [cfa_pkg::STAT_W-1:0]      out_tuser,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);
  import cfa_pkg::*;

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // only a grant carries a block and a remaining size
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STAT_ALLOCATED) |-> out_tdata == '0)
    else $error("non-grant result with nonzero payload");

  // one item at a time: no input transfer right after another
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in progress");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind contiguous_fit_allocator_top cfa_checker u_cfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);
